>>> src/ikvl_pkg.sv
// ----------------------------------------------------------------------------
// ikvl_pkg: shared types and constants for the INI key/value lookup
// Character codes, scan modes, register indexes and small helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package ikvl_pkg;

  // Largest section or key name that the registers can hold, in bytes.
  localparam int unsigned MAX_NAME_BYTES = 8;
  // Default limit on the number of value bytes delivered.
  localparam int unsigned MAX_VALUE_BYTES_DEF = 31;

  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned LEN_W       = 4;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_SECTION_TEXT   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SECTION_LENGTH = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_TEXT       = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_LENGTH     = 2'd3;

  // Characters that steer the scan.
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_EQUALS = 8'h3D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;

  // Scan modes, one-hot.
  typedef enum logic [10:0] {
    MODE_SEEK_SECTION    = 11'b000_0000_0001,
    MODE_SECTION_COMMENT = 11'b000_0000_0010,
    MODE_MATCH_SECTION   = 11'b000_0000_0100,
    MODE_SECTION_TAIL    = 11'b000_0000_1000,
    MODE_SEEK_KEY        = 11'b000_0001_0000,
    MODE_KEY_COMMENT     = 11'b000_0010_0000,
    MODE_MATCH_KEY       = 11'b000_0100_0000,
    MODE_SKIP_KEY_LINE   = 11'b000_1000_0000,
    MODE_AFTER_KEY       = 11'b001_0000_0000,
    MODE_READ_VALUE      = 11'b010_0000_0000,
    MODE_DONE            = 11'b100_0000_0000
  } mode_t;

  // Space, tab, carriage return and line feed count as blanks.
  function automatic logic is_blank(input logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_LF) || (b == CH_CR) || (b == CH_TAB);
  endfunction

  // A length above the register capacity counts as the full capacity.
  function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] n);
    return (n > LEN_W'(MAX_NAME_BYTES)) ? LEN_W'(MAX_NAME_BYTES) : n;
  endfunction

  // Byte of a packed name, first character in the lowest byte.
  function automatic logic [7:0] name_byte(input logic [CFG_DATA_W-1:0] text,
                                           input logic [2:0] pos);
    return text[{pos, 3'b000} +: 8];
  endfunction

endpackage

`default_nettype wire

>>> src/ikvl_if.sv
// ----------------------------------------------------------------------------
// ikvl channel interfaces
// Valid/ready channels for the text byte stream and the lookup results.
// ----------------------------------------------------------------------------
`default_nettype none

interface ikvl_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink (input valid, input text_byte, output ready);
endinterface

interface ikvl_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] value_byte;
  logic       finished;
  logic       found;

  modport source (output valid, output value_byte, output finished, output found,
                  input ready);
  modport sink (input valid, input value_byte, input finished, input found,
                output ready);
endinterface

`default_nettype wire

>>> src/ini_key_value_lookup_top.sv
// ----------------------------------------------------------------------------
// ini_key_value_lookup_top: INI section/key lookup over a byte stream
// Scans text for a configured section and key and returns the value bytes.
// ----------------------------------------------------------------------------
//  channel     direction  payload                          transfer when
//  text_in     in         text_byte[7:0]                   valid & ready
//  result_out  out        value_byte[7:0], finished, found valid & ready
//  cfg_*       in         cfg_index[1:0], cfg_data[63:0]   cfg_write
//
// One text byte is taken per cycle; its result, if any, appears in the
// output register on the next cycle. The scan mode update is a single
// compare-and-select step, so bytes can follow each other without gaps.
// A byte is taken whenever the output register is empty or being drained.
// Reset (synchronous, active high) clears all configuration registers and
// arms the search for the section.
// ----------------------------------------------------------------------------
`default_nettype none

module ini_key_value_lookup_top #(
  parameter int unsigned MAX_VALUE_BYTES = ikvl_pkg::MAX_VALUE_BYTES_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  ikvl_text_if.sink                               text_in,
  ikvl_result_if.source                           result_out,
  input  wire logic                               cfg_write,
  input  wire logic [ikvl_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [ikvl_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import ikvl_pkg::*;

  localparam int unsigned CountW = $clog2(MAX_VALUE_BYTES + 1);

  // Configuration registers.
  logic [CFG_DATA_W-1:0] section_text;
  logic [LEN_W-1:0]      section_length;
  logic [CFG_DATA_W-1:0] key_text;
  logic [LEN_W-1:0]      key_length;

  // Scan state.
  mode_t             mode, mode_next;
  logic [LEN_W-1:0]  pos, pos_next;
  logic              spoiled, spoiled_next;
  logic [CountW-1:0] count, count_next;

  // Result of the byte under evaluation.
  logic       emit;
  logic [7:0] res_byte;
  logic       res_finished;
  logic       res_found;

  logic       accept;
  logic [7:0] b;
  logic [LEN_W-1:0] sec_len;
  logic [LEN_W-1:0] key_len;
  logic [LEN_W-1:0] pos_inc;

  assign text_in.ready = !result_out.valid || result_out.ready;
  assign accept        = text_in.valid && text_in.ready;
  assign b             = text_in.text_byte;
  assign sec_len       = clamp_len(section_length);
  assign key_len       = clamp_len(key_length);
  assign pos_inc       = pos + LEN_W'(1);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      section_text   <= '0;
      section_length <= '0;
      key_text       <= '0;
      key_length     <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_SECTION_TEXT:   section_text   <= cfg_data;
        CFG_SECTION_LENGTH: section_length <= cfg_data[LEN_W-1:0];
        CFG_KEY_TEXT:       key_text       <= cfg_data;
        CFG_KEY_LENGTH:     key_length     <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Next scan state and result for the incoming byte.
  always_comb begin
    mode_next    = mode;
    pos_next     = pos;
    spoiled_next = spoiled;
    count_next   = count;
    emit         = 1'b0;
    res_byte     = '0;
    res_finished = 1'b0;
    res_found    = 1'b0;

    if (b == CH_NUL) begin
      // End of text: report unless already done, then rearm.
      if (mode != MODE_DONE) begin
        emit         = 1'b1;
        res_finished = 1'b1;
        res_found    = (mode == MODE_READ_VALUE);
      end
      mode_next    = MODE_SEEK_SECTION;
      pos_next     = '0;
      spoiled_next = 1'b0;
      count_next   = '0;
    end else begin
      unique case (mode)
        MODE_SEEK_SECTION, MODE_MATCH_SECTION: begin
          if (mode == MODE_MATCH_SECTION && b == CH_RBRACK) begin
            mode_next = MODE_SEEK_SECTION;
          end else if (mode == MODE_MATCH_SECTION &&
                       b == name_byte(section_text, pos[2:0])) begin
            pos_next = pos_inc;
            if (pos_inc >= sec_len) begin
              spoiled_next = 1'b0;
              mode_next    = MODE_SECTION_TAIL;
            end
          end else begin
            // Seek a header; a mismatching byte is looked at afresh.
            mode_next = MODE_SEEK_SECTION;
            if (b == CH_HASH) begin
              mode_next = MODE_SECTION_COMMENT;
            end else if (b == CH_LBRACK) begin
              pos_next     = '0;
              spoiled_next = 1'b0;
              mode_next    = (sec_len == '0) ? MODE_SECTION_TAIL : MODE_MATCH_SECTION;
            end
          end
        end
        MODE_SECTION_COMMENT: begin
          if (b == CH_LF) mode_next = MODE_SEEK_SECTION;
        end
        MODE_SECTION_TAIL: begin
          if (b == CH_RBRACK) begin
            mode_next    = spoiled ? MODE_SEEK_SECTION : MODE_SEEK_KEY;
            spoiled_next = 1'b0;
            pos_next     = '0;
          end else if (!is_blank(b)) begin
            spoiled_next = 1'b1;
          end
        end
        MODE_SEEK_KEY, MODE_MATCH_KEY, MODE_AFTER_KEY: begin
          if (mode == MODE_SEEK_KEY && b == CH_LBRACK) begin
            // A new section ends the search without a match.
            emit         = 1'b1;
            res_finished = 1'b1;
            mode_next    = MODE_DONE;
            pos_next     = '0;
            spoiled_next = 1'b0;
            count_next   = '0;
          end else if (mode == MODE_SEEK_KEY && b == CH_HASH) begin
            mode_next = MODE_KEY_COMMENT;
          end else if (mode == MODE_SEEK_KEY && is_blank(b)) begin
            mode_next = MODE_SEEK_KEY;
          end else if (mode == MODE_AFTER_KEY ||
                       (mode == MODE_SEEK_KEY && key_len == '0)) begin
            // Past the key name: wait for the equals sign.
            if (mode == MODE_SEEK_KEY) pos_next = '0;
            if (b == CH_EQUALS) begin
              count_next = '0;
              mode_next  = MODE_READ_VALUE;
            end else if (!is_blank(b)) begin
              mode_next = MODE_SKIP_KEY_LINE;
            end else begin
              mode_next = MODE_AFTER_KEY;
            end
          end else begin
            // Compare one key character; a new key line starts at zero.
            if (mode == MODE_SEEK_KEY) begin
              if (b != name_byte(key_text, 3'd0)) begin
                pos_next  = '0;
                mode_next = MODE_SKIP_KEY_LINE;
              end else begin
                pos_next  = LEN_W'(1);
                mode_next = (LEN_W'(1) >= key_len) ? MODE_AFTER_KEY : MODE_MATCH_KEY;
              end
            end else if (b != name_byte(key_text, pos[2:0])) begin
              mode_next = (b == CH_LF) ? MODE_SEEK_KEY : MODE_SKIP_KEY_LINE;
            end else begin
              pos_next  = pos_inc;
              mode_next = (pos_inc >= key_len) ? MODE_AFTER_KEY : MODE_MATCH_KEY;
            end
          end
        end
        MODE_KEY_COMMENT: begin
          if (b == CH_LF) mode_next = MODE_SEEK_KEY;
        end
        MODE_SKIP_KEY_LINE: begin
          mode_next = (b == CH_LF) ? MODE_SEEK_KEY : MODE_SKIP_KEY_LINE;
        end
        MODE_READ_VALUE: begin
          if (b == CH_HASH || is_blank(b)) begin
            emit         = 1'b1;
            res_finished = 1'b1;
            res_found    = 1'b1;
            mode_next    = MODE_DONE;
            pos_next     = '0;
            spoiled_next = 1'b0;
            count_next   = '0;
          end else if (count < CountW'(MAX_VALUE_BYTES)) begin
            count_next = count + CountW'(1);
            emit       = 1'b1;
            res_byte   = b;
            res_found  = 1'b1;
          end
        end
        default: begin
          // Done: ignore everything until the end of the text.
          mode_next = MODE_DONE;
        end
      endcase
    end
  end

  // Scan state advances on every accepted byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= MODE_SEEK_SECTION;
      pos     <= '0;
      spoiled <= 1'b0;
      count   <= '0;
    end else if (accept) begin
      mode    <= mode_next;
      pos     <= pos_next;
      spoiled <= spoiled_next;
      count   <= count_next;
    end
  end

  // Output register: loads a result, empties when the transfer completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_out.valid <= 1'b0;
    end else if (accept && emit) begin
      result_out.valid <= 1'b1;
    end else if (result_out.ready) begin
      result_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      result_out.value_byte <= res_byte;
      result_out.finished   <= res_finished;
      result_out.found      <= res_found;
    end
  end

  // Checks on the scan logic.
  a_value_is_found: assert property (@(posedge clk) disable iff (rst)
    result_out.valid && !result_out.finished |-> result_out.found)
    else $error("value byte delivered without found set");

  a_finish_zero_byte: assert property (@(posedge clk) disable iff (rst)
    result_out.valid && result_out.finished |-> result_out.value_byte == 8'h00)
    else $error("finishing result carries a non-zero value byte");

  a_nul_rearms: assert property (@(posedge clk) disable iff (rst)
    accept && text_in.text_byte == CH_NUL |=> mode == MODE_SEEK_SECTION && count == '0)
    else $error("end of text did not rearm the search");

  a_done_silent: assert property (@(posedge clk) disable iff (rst)
    accept && mode == MODE_DONE && text_in.text_byte != CH_NUL |=> !result_out.valid ||
    $stable(result_out.value_byte) && $stable(result_out.finished))
    else $error("result produced after the lookup ended");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CountW'(MAX_VALUE_BYTES))
    else $error("value byte count exceeds its limit");

endmodule

`default_nettype wire

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// INI key/value lookup testbench
// Streams INI text into the lookup block over valid/ready channels and checks
// every value byte and end-of-lookup marker against an internal model of the
// scan. Directed texts cover comments, header and key mismatches, empty and
// over-long names, value overflow and the end-of-text cases. Random documents
// follow under changing section and key registers, with random idle cycles
// on the text side and random stalls on the result side.
// ----------------------------------------------------------------------------
module testbench;
  import ikvl_pkg::*;

  localparam int VALUE_LIMIT   = MAX_VALUE_BYTES_DEF;
  localparam int RANDOM_ITEMS  = 1600;
  localparam int QUIET_TAIL    = 300;
  localparam int CFG_EVERY     = 200;
  localparam int DRAIN_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 4;
  localparam int TIMEOUT       = 2_000_000;

  // One result of the lookup as it appears on the result channel.
  typedef struct packed {
    logic [7:0] value_byte;
    logic       finished;
    logic       found;
  } lookup_out_t;

  logic clk;
  logic rst;
  logic cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  ikvl_text_if text_if ();
  ikvl_result_if result_if ();

  ini_key_value_lookup_top #(
    .MAX_VALUE_BYTES(VALUE_LIMIT)
  ) dut (
    .clk(clk),
    .rst(rst),
    .text_in(text_if),
    .result_out(result_if),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Model copies of the registers and of the scan state.
  logic [63:0] sec_name_reg;
  logic [3:0]  sec_len_reg;
  logic [63:0] key_name_reg;
  logic [3:0]  key_len_reg;
  mode_t       scan_mode;
  logic [3:0]  match_pos;
  logic        header_spoiled;
  logic [7:0]  value_count;

  lookup_out_t lookup_out_q[$];
  logic [7:0]  ini_text[$];
  int          items_sent;
  int          error_count;
  int          send_gap_pct;
  int          stall_pct;
  int          stall_left;

  // Clock generation.
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Watchdog for a hung handshake.
  initial begin
    #(TIMEOUT);
    $display("TEST FAILED");
    $finish;
  end

  // ------------------------------------------------------------------------
  // Scan model
  // ------------------------------------------------------------------------
  function automatic bit is_space_char(logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_LF) || (b == CH_CR) || (b == CH_TAB);
  endfunction

  // Lengths above the register capacity use the whole register.
  function automatic int name_span(logic [3:0] n);
    return (n > MAX_NAME_BYTES) ? MAX_NAME_BYTES : int'(n);
  endfunction

  function automatic logic [7:0] name_char(logic [63:0] text, logic [3:0] pos);
    logic [63:0] shifted;
    shifted = text >> (8 * pos[2:0]);
    return shifted[7:0];
  endfunction

  function automatic void close_lookup(bit rearm);
    scan_mode = rearm ? MODE_SEEK_SECTION : MODE_DONE;
    match_pos = '0;
    header_spoiled = 1'b0;
    value_count = '0;
  endfunction

  function automatic void look_for_header(logic [7:0] b);
    if (b == CH_HASH) begin
      scan_mode = MODE_SECTION_COMMENT;
    end else if (b == CH_LBRACK) begin
      match_pos = '0;
      header_spoiled = 1'b0;
      scan_mode = (name_span(sec_len_reg) == 0) ? MODE_SECTION_TAIL : MODE_MATCH_SECTION;
    end
  endfunction

  function automatic void skip_rest_of_line(logic [7:0] b);
    scan_mode = (b == CH_LF) ? MODE_SEEK_KEY : MODE_SKIP_KEY_LINE;
  endfunction

  function automatic void after_key_name(logic [7:0] b);
    if (b == CH_EQUALS) begin
      value_count = '0;
      scan_mode = MODE_READ_VALUE;
    end else if (!is_space_char(b)) begin
      skip_rest_of_line(b);
    end else begin
      scan_mode = MODE_AFTER_KEY;
    end
  endfunction

  function automatic void match_key_char(logic [7:0] b);
    if (b != name_char(key_name_reg, match_pos)) begin
      skip_rest_of_line(b);
    end else begin
      match_pos++;
      scan_mode = (match_pos >= name_span(key_len_reg)) ? MODE_AFTER_KEY : MODE_MATCH_KEY;
    end
  endfunction

  // Advance the model by one accepted text byte and queue any result.
  task automatic scan_text_byte(input logic [7:0] b);
    lookup_out_t r;
    bit emit;
    r = '{value_byte: 8'h00, finished: 1'b1, found: 1'b0};
    emit = 1'b0;
    if (b == CH_NUL) begin
      // End of text: report unless the lookup already ended, then rearm.
      emit = (scan_mode != MODE_DONE);
      r.found = (scan_mode == MODE_READ_VALUE);
      close_lookup(1'b1);
    end else begin
      case (scan_mode)
        MODE_SEEK_SECTION: look_for_header(b);
        MODE_SECTION_COMMENT: begin
          if (b == CH_LF) scan_mode = MODE_SEEK_SECTION;
        end
        MODE_MATCH_SECTION: begin
          if (b == CH_RBRACK) begin
            scan_mode = MODE_SEEK_SECTION;
          end else if (b != name_char(sec_name_reg, match_pos)) begin
            scan_mode = MODE_SEEK_SECTION;
            look_for_header(b);
          end else begin
            match_pos++;
            if (match_pos >= name_span(sec_len_reg)) begin
              header_spoiled = 1'b0;
              scan_mode = MODE_SECTION_TAIL;
            end
          end
        end
        MODE_SECTION_TAIL: begin
          if (b == CH_RBRACK) begin
            scan_mode = header_spoiled ? MODE_SEEK_SECTION : MODE_SEEK_KEY;
            header_spoiled = 1'b0;
            match_pos = '0;
          end else if (!is_space_char(b)) begin
            header_spoiled = 1'b1;
          end
        end
        MODE_SEEK_KEY: begin
          if (b == CH_LBRACK) begin
            emit = 1'b1;
            close_lookup(1'b0);
          end else if (b == CH_HASH) begin
            scan_mode = MODE_KEY_COMMENT;
          end else if (!is_space_char(b)) begin
            match_pos = '0;
            if (name_span(key_len_reg) == 0) after_key_name(b);
            else match_key_char(b);
          end
        end
        MODE_KEY_COMMENT: begin
          if (b == CH_LF) scan_mode = MODE_SEEK_KEY;
        end
        MODE_MATCH_KEY: match_key_char(b);
        MODE_SKIP_KEY_LINE: skip_rest_of_line(b);
        MODE_AFTER_KEY: after_key_name(b);
        MODE_READ_VALUE: begin
          if (b == CH_HASH || is_space_char(b)) begin
            emit = 1'b1;
            r.found = 1'b1;
            close_lookup(1'b0);
          end else if (value_count < VALUE_LIMIT) begin
            value_count++;
            emit = 1'b1;
            r = '{value_byte: b, finished: 1'b0, found: 1'b1};
          end
        end
        default: scan_mode = MODE_DONE;
      endcase
    end
    if (emit) lookup_out_q.insert(lookup_out_q.size(), r);
  endtask

  // ------------------------------------------------------------------------
  // Result side: random stalls and checking
  // ------------------------------------------------------------------------
  always @(posedge clk) begin
    if (stall_left != 0) begin
      result_if.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
      result_if.ready <= 1'b0;
      stall_left <= $urandom_range(0, 2);
    end else begin
      result_if.ready <= 1'b1;
    end
  end

  // Compare each result transfer with the oldest expected one.
  always @(posedge clk) begin : check_results
    lookup_out_t want;
    if (!rst && result_if.valid === 1'b1 && result_if.ready === 1'b1) begin
      if (lookup_out_q.size() == 0) begin
        $error("unexpected result: value_byte %02h finished %0b found %0b",
               result_if.value_byte, result_if.finished, result_if.found);
        error_count++;
      end else begin
        want = lookup_out_q.pop_front();
        if (result_if.finished !== want.finished) begin
          $error("finished: expected %0b, actual %0b", want.finished, result_if.finished);
          error_count++;
        end
        if (result_if.found !== want.found) begin
          $error("found: expected %0b, actual %0b", want.found, result_if.found);
          error_count++;
        end
        if (!want.finished && result_if.value_byte !== want.value_byte) begin
          $error("value_byte: expected %02h, actual %02h", want.value_byte,
                 result_if.value_byte);
          error_count++;
        end
      end
    end
  end

  // ------------------------------------------------------------------------
  // Text side
  // ------------------------------------------------------------------------
  // Send one byte; valid stays high afterwards so that bytes can follow
  // back to back.
  task automatic send_byte(input logic [7:0] b);
    if (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct) begin
      text_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    text_if.valid <= 1'b1;
    text_if.text_byte <= b;
    do @(posedge clk); while (text_if.ready !== 1'b1);
    scan_text_byte(b);
    items_sent++;
  endtask

  task automatic send_text();
    foreach (ini_text[i]) send_byte(ini_text[i]);
    ini_text.delete();
  endtask

  // Stop sending, wait for every pending result, then let the pipeline settle.
  task automatic drain_lookup();
    int waited;
    waited = 0;
    text_if.valid <= 1'b0;
    while (lookup_out_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (lookup_out_q.size() != 0) begin
      $error("%0d expected results never arrived", lookup_out_q.size());
      error_count++;
      lookup_out_q.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all four lookup registers while the block is idle.
  task automatic configure(input logic [63:0] sec_name, input logic [3:0] sec_len,
                           input logic [63:0] key_name, input logic [3:0] key_len);
    drain_lookup();
    cfg_write <= 1'b1;
    cfg_index <= CFG_SECTION_TEXT;
    cfg_data <= sec_name;
    @(posedge clk);
    cfg_index <= CFG_SECTION_LENGTH;
    cfg_data <= 64'(sec_len);
    @(posedge clk);
    cfg_index <= CFG_KEY_TEXT;
    cfg_data <= key_name;
    @(posedge clk);
    cfg_index <= CFG_KEY_LENGTH;
    cfg_data <= 64'(key_len);
    @(posedge clk);
    cfg_write <= 1'b0;
    sec_name_reg = sec_name;
    sec_len_reg = sec_len;
    key_name_reg = key_name;
    key_len_reg = key_len;
  endtask

  // ------------------------------------------------------------------------
  // Text building
  // ------------------------------------------------------------------------
  // Append one character to the text under construction.
  task automatic append_char(input logic [7:0] c);
    ini_text.insert(ini_text.size(), c);
  endtask

  function automatic logic [7:0] plain_char();
    string alphabet;
    alphabet = "abcdefghijklmnopqrstuvwxyz0123456789_.";
    return alphabet[$urandom_range(0, alphabet.len() - 1)];
  endfunction

  // Any non-zero byte that does not end a value.
  function automatic logic [7:0] value_char();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255)); while (b == CH_HASH || is_space_char(b));
    return b;
  endfunction

  function automatic logic [7:0] blank_char();
    case ($urandom_range(0, 3))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_CR;
      default: return CH_LF;
    endcase
  endfunction

  function automatic logic [63:0] random_name(bit plain_only);
    logic [63:0] n;
    for (int i = 0; i < 8; i++) begin
      if (!plain_only && $urandom_range(0, 7) == 0) n[8*i +: 8] = 8'($urandom_range(1, 255));
      else n[8*i +: 8] = plain_char();
    end
    return n;
  endfunction

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) append_char(s[i]);
  endtask

  task automatic add_name(input logic [63:0] name, input logic [3:0] len);
    for (int i = 0; i < name_span(len); i++) append_char(name[8*i +: 8]);
  endtask

  task automatic add_header(input bit spoil);
    append_char(CH_LBRACK);
    add_name(sec_name_reg, sec_len_reg);
    if ($urandom_range(0, 2) == 0) append_char(blank_char());
    if (spoil) append_char(plain_char());
    add_text("]\n");
  endtask

  // Key line for the configured key, with blanks and a random value.
  task automatic add_key_line();
    int n;
    repeat ($urandom_range(0, 2)) append_char(blank_char());
    add_name(key_name_reg, key_len_reg);
    repeat ($urandom_range(0, 2)) append_char(CH_SPACE);
    append_char(CH_EQUALS);
    n = ($urandom_range(0, 4) == 0) ? $urandom_range(28, 36) : $urandom_range(0, 6);
    repeat (n) append_char(value_char());
    if ($urandom_range(0, 3) == 0) append_char(CH_HASH);
    else append_char(blank_char());
    append_char(CH_LF);
  endtask

  task automatic add_random_line();
    case ($urandom_range(0, 10))
      0: begin
        append_char(CH_HASH);
        repeat ($urandom_range(0, 4)) append_char(value_char());
        append_char(CH_LF);
      end
      1: add_header(1'b0);
      2: add_header(1'b1);
      3: begin
        append_char(CH_LBRACK);
        repeat ($urandom_range(1, 4)) append_char(plain_char());
        add_text("]\n");
      end
      4, 5, 6: add_key_line();
      7: begin
        // Key name followed by extra text.
        add_name(key_name_reg, key_len_reg);
        append_char(plain_char());
        add_text("=x\n");
      end
      8: begin
        repeat ($urandom_range(1, 3)) append_char(plain_char());
        append_char(CH_EQUALS);
        append_char(plain_char());
        append_char(CH_LF);
      end
      9: repeat ($urandom_range(1, 3)) append_char(blank_char());
      default: repeat ($urandom_range(1, 6)) append_char(8'($urandom_range(1, 255)));
    endcase
  endtask

  // A short document, mostly well formed, usually ended by a zero byte.
  task automatic build_random_doc();
    repeat ($urandom_range(0, 2)) add_random_line();
    if ($urandom_range(0, 4) != 0) add_header(1'b0);
    repeat ($urandom_range(1, 5)) add_random_line();
    if ($urandom_range(0, 9) != 0) append_char(CH_NUL);
  endtask

  // ------------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------------
  task automatic reset_block();
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    text_if.valid = 1'b0;
    text_if.text_byte = '0;
    result_if.ready = 1'b0;
    items_sent = 0;
    error_count = 0;
    send_gap_pct = 0;
    stall_pct = 0;
    stall_left = 0;
    sec_name_reg = '0;
    sec_len_reg = '0;
    key_name_reg = '0;
    key_len_reg = '0;
    close_lookup(1'b1);
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
  endtask

  // Comments, a header mismatch that restarts on '[', a key with trailing
  // text, a found value, bytes ignored after the end and both zero cases.
  task automatic test_section_and_key_scan();
    configure(64'h6261, 4'd2, 64'h6b, 4'd1);
    add_text("#[ab]\n[a[ab ]\n kx=\nk =v");
    append_char(8'hFF);
    add_text("#[zz");
    append_char(CH_NUL);
    append_char(CH_NUL);
    send_text();
  endtask

  // Empty section matches a bracket pair with blanks; empty key wants '='.
  task automatic test_empty_names();
    configure(random_name(1'b0), 4'd0, random_name(1'b0), 4'd0);
    add_text("[ ]\n x=1\n =v");
    append_char(CH_NUL);
    send_text();
  endtask

  // Full-length section, over-long key length and a value past the limit.
  task automatic test_long_names_and_overflow();
    configure(random_name(1'b1), 4'd8, random_name(1'b1), 4'd15);
    add_header(1'b0);
    add_name(key_name_reg, key_len_reg);
    append_char(CH_EQUALS);
    repeat (VALUE_LIMIT + 3) append_char(value_char());
    append_char(CH_TAB);
    send_text();
  endtask

  // A ']' inside the section name, a spoiled header, and a new header that
  // ends the key search.
  task automatic test_header_rejects();
    configure(64'h5d61, 4'd2, 64'h6b, 4'd1);
    add_text("[a]");
    append_char(CH_NUL);
    send_text();
    configure(64'h6261, 4'd2, 64'h6b, 4'd1);
    add_text("[abx]\n[ab]\n[");
    append_char(CH_NUL);
    append_char(CH_NUL);
    send_text();
  endtask

  task automatic test_random_documents();
    int start;
    int docs;
    int next_cfg;
    int cfg_round;
    bit quiet;
    start = items_sent;
    docs = 0;
    next_cfg = 0;
    cfg_round = 0;
    while (items_sent - start < RANDOM_ITEMS) begin
      // The last stretch runs without any idle cycle on either side.
      quiet = (items_sent - start) > (RANDOM_ITEMS - QUIET_TAIL);
      // New register settings at regular points; extremes come first.
      if (!quiet && items_sent - start >= next_cfg) begin
        case (cfg_round)
          0: configure('1, 4'hF, '0, 4'h0);
          1: configure('0, 4'h0, '1, 4'd8);
          default: configure(random_name(1'b0),
                             ($urandom_range(0, 5) == 0) ? 4'($urandom_range(9, 15))
                                                         : 4'($urandom_range(0, 8)),
                             random_name(1'b0),
                             ($urandom_range(0, 5) == 0) ? 4'($urandom_range(9, 15))
                                                         : 4'($urandom_range(0, 8)));
        endcase
        cfg_round++;
        next_cfg += CFG_EVERY;
      end
      send_gap_pct = (quiet || $urandom_range(0, 2) == 0) ? 0 : 25;
      stall_pct = (quiet || $urandom_range(0, 2) == 0) ? 0 : 25;
      build_random_doc();
      send_text();
      docs++;
      // Now and then hold off until the block has delivered everything.
      if (!quiet && docs % 16 == 5) drain_lookup();
    end
  endtask

  initial begin
    reset_block();
    send_gap_pct = 25;
    stall_pct = 25;
    test_section_and_key_scan();
    test_empty_names();
    test_long_names_and_overflow();
    test_header_rejects();
    test_random_documents();
    drain_lookup();
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
